// ===== sv/toeq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toeq_pkg
// Types and constants shared by the event queue cells and the top level.
// ----------------------------------------------------------------------------
package toeq_pkg;

  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int TIME_W = 32;
  localparam int DATA_W = 32;
  localparam int OCC_W = 7;

  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_FULL   = 2'd1,
    ST_POPPED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    logic [TIME_W-1:0] ev_time;
    logic              ev_kind;
    logic [DATA_W-1:0] ev_data;
  } event_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic   push_en;
    logic   pop_en;
    event_t new_ev;
  } cell_ctl_t;

endpackage

// ===== sv/toeq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toeq_cell
// One slot of the sorted chain: compares against the broadcast event and
// shifts towards the tail on push or towards the head on pop.
// ----------------------------------------------------------------------------
module toeq_cell (
  input  logic                clk,
  input  toeq_pkg::cell_ctl_t ctl,
  input  logic                occupied,
  input  toeq_pkg::event_t    prev_ev,
  input  logic                prev_later,
  input  toeq_pkg::event_t    next_ev,
  output toeq_pkg::event_t    ev,
  output logic                later
);

  toeq_pkg::event_t ev_r;
  toeq_pkg::event_t ev_nxt;

  // an empty slot counts as later than anything
  assign later = !occupied || (ev_r.ev_time > ctl.new_ev.ev_time);
  assign ev    = ev_r;

  always_comb begin
    ev_nxt = ev_r;
    if (ctl.push_en) begin
      if (prev_later) begin
        ev_nxt = prev_ev;
      end else if (later) begin
        ev_nxt = ctl.new_ev;
      end
    end else if (ctl.pop_en) begin
      ev_nxt = next_ev;
    end
  end

  always_ff @(posedge clk) begin
    ev_r <= ev_nxt;
  end

endmodule

// ===== sv/timestamp_ordered_event_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_ordered_event_queue
// Sorted insertion queue of timed events built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle and returns its result in the cycle
// after from an output register; in_ready drops only while that register
// holds a result that out_ready has not taken. Each slot cell compares its
// own timestamp with the broadcast one and all cells shift together, so the
// cost per request is one 32-bit compare per cell plus the neighbour select.
// Equal timestamps keep arrival order. After reset the queue is empty and
// ready at once; a push to a full queue is dropped and reported, a pop on an
// empty queue reports empty and changes nothing.
module timestamp_ordered_event_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [31:0] in_event_time,
  input  logic        in_event_kind,
  input  logic [31:0] in_event_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_time,
  output logic        out_kind,
  output logic [31:0] out_data,
  output logic [6:0]  out_occupancy
);

  localparam int D = toeq_pkg::DEPTH;
  localparam int CW = toeq_pkg::CNT_W;

  logic [CW-1:0]       count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  toeq_pkg::status_t   status_r, status_nxt;
  toeq_pkg::event_t    res_ev_r, res_ev_nxt;
  logic [CW-1:0]       occ_r;
  logic [CW+toeq_pkg::OCC_W-1:0] occ_ext;

  toeq_pkg::cell_ctl_t ctl;
  toeq_pkg::event_t    cell_ev [D];
  logic [D-1:0]        cell_later;
  logic [D-1:0]        cell_occ;
  logic                accept;
  logic                is_full;
  logic                is_empty;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = (count_r == CW'(D));
  assign is_empty = (count_r == '0);

  assign ctl.new_ev.ev_time = in_event_time;
  assign ctl.new_ev.ev_kind = in_event_kind;
  assign ctl.new_ev.ev_data = in_event_data;
  assign ctl.push_en = accept && (toeq_pkg::op_t'(in_operation) == toeq_pkg::OP_PUSH)
                       && !is_full;
  assign ctl.pop_en  = accept && (toeq_pkg::op_t'(in_operation) == toeq_pkg::OP_POP)
                       && !is_empty;

  for (genvar i = 0; i < D; i++) begin : g_cell
    assign cell_occ[i] = (count_r > CW'(i));
    toeq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (cell_occ[i]),
      .prev_ev    ((i == 0) ? ctl.new_ev : cell_ev[(i == 0) ? 0 : i - 1]),
      .prev_later ((i == 0) ? 1'b0 : cell_later[(i == 0) ? 0 : i - 1]),
      .next_ev    (cell_ev[(i == D - 1) ? i : i + 1]),
      .ev         (cell_ev[i]),
      .later      (cell_later[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    res_ev_nxt    = res_ev_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      res_ev_nxt    = '0;
      if (toeq_pkg::op_t'(in_operation) == toeq_pkg::OP_PUSH) begin
        if (is_full) begin
          status_nxt = toeq_pkg::ST_FULL;
        end else begin
          status_nxt = toeq_pkg::ST_PUSHED;
          count_nxt  = count_r + CW'(1);
        end
      end else begin
        if (is_empty) begin
          status_nxt = toeq_pkg::ST_EMPTY;
        end else begin
          status_nxt = toeq_pkg::ST_POPPED;
          res_ev_nxt = cell_ev[0];
          count_nxt  = count_r - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
    res_ev_r <= res_ev_nxt;
    if (accept) begin
      occ_r <= count_nxt;
    end
  end

  assign occ_ext       = {{toeq_pkg::OCC_W{1'b0}}, occ_r};
  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_time      = res_ev_r.ev_time;
  assign out_kind      = res_ev_r.ev_kind;
  assign out_data      = res_ev_r.ev_data;
  assign out_occupancy = occ_ext[toeq_pkg::OCC_W-1:0];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(D))
    else $error("stored count above depth");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CW'(2)) |-> (cell_ev[0].ev_time <= cell_ev[1].ev_time))
    else $error("head slots out of order");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == toeq_pkg::ST_FULL) |-> (occ_r == CW'(D)))
    else $error("full result without full occupancy");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == toeq_pkg::ST_EMPTY) |-> (occ_r == '0))
    else $error("empty result with nonzero occupancy");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop_en |=> (count_r == $past(count_r) - CW'(1)))
    else $error("pop did not remove one event");

endmodule

// ===== dv/timestamp_ordered_event_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_ordered_event_queue_tb
// Self-checking bench for the sorted insertion event queue.
// ----------------------------------------------------------------------------
// Requests go in through a valid/ready driver with random gaps, results are
// taken with random back-pressure. A shadow copy of the sorted store works
// out the status, popped event and occupancy of every accepted request, and
// each result taken from the block is checked against the oldest of them.
// Covers empty pops, extreme field values, ties on timestamp, filling past
// full and long mixed traffic that wanders between empty and full.
module timestamp_ordered_event_queue_tb;

  localparam int IDLE_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    toeq_pkg::status_t status;
    logic [31:0]       ev_time;
    logic              ev_kind;
    logic [31:0]       ev_data;
    logic [6:0]        occupancy;
  } queue_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [31:0] in_event_time;
  logic        in_event_kind;
  logic [31:0] in_event_data;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_time;
  logic        out_kind;
  logic [31:0] out_data;
  logic [6:0]  out_occupancy;

  // shadow of the sorted store, head at slot 0
  logic [31:0] shadow_time [toeq_pkg::DEPTH];
  logic        shadow_kind [toeq_pkg::DEPTH];
  logic [31:0] shadow_data [toeq_pkg::DEPTH];
  int          shadow_count;

  queue_result_t pending_results[$];
  int            fail_count;
  bit            steady_flow;

  timestamp_ordered_event_queue dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_event_time (in_event_time),
    .in_event_kind (in_event_kind),
    .in_event_data (in_event_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_time      (out_time),
    .out_kind      (out_kind),
    .out_data      (out_data),
    .out_occupancy (out_occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // apply one request to the shadow store and return what the block should report
  function automatic queue_result_t apply_to_shadow(toeq_pkg::op_t op, logic [31:0] t,
                                                    logic k, logic [31:0] d);
    queue_result_t res;
    int pos;
    res = '0;
    if (op == toeq_pkg::OP_PUSH) begin
      if (shadow_count >= toeq_pkg::DEPTH) begin
        res.status = toeq_pkg::ST_FULL;
      end else begin
        pos = shadow_count;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_time[i] > t) begin
            pos = i;
            break;
          end
        end
        for (int i = shadow_count; i > pos; i--) begin
          shadow_time[i] = shadow_time[i-1];
          shadow_kind[i] = shadow_kind[i-1];
          shadow_data[i] = shadow_data[i-1];
        end
        shadow_time[pos] = t;
        shadow_kind[pos] = k;
        shadow_data[pos] = d;
        shadow_count++;
        res.status = toeq_pkg::ST_PUSHED;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = toeq_pkg::ST_EMPTY;
      end else begin
        res.ev_time = shadow_time[0];
        res.ev_kind = shadow_kind[0];
        res.ev_data = shadow_data[0];
        for (int i = 0; i + 1 < shadow_count; i++) begin
          shadow_time[i] = shadow_time[i+1];
          shadow_kind[i] = shadow_kind[i+1];
          shadow_data[i] = shadow_data[i+1];
        end
        shadow_count--;
        res.status = toeq_pkg::ST_POPPED;
      end
    end
    res.occupancy = 7'(shadow_count);
    return res;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s", $time, msg);
  endtask

  task automatic check_result();
    queue_result_t exp_res;
    queue_result_t got;
    got.status = toeq_pkg::status_t'(out_status);
    got.ev_time = out_time;
    got.ev_kind = out_kind;
    got.ev_data = out_data;
    got.occupancy = out_occupancy;
    if (pending_results.size() == 0) begin
      note_failure($sformatf("result with nothing outstanding: status %0d time %h occ %0d",
                             got.status, got.ev_time, got.occupancy));
    end else begin
      exp_res = pending_results.pop_front();
      if (got.status !== exp_res.status || got.ev_time !== exp_res.ev_time ||
          got.ev_kind !== exp_res.ev_kind || got.ev_data !== exp_res.ev_data ||
          got.occupancy !== exp_res.occupancy)
        note_failure($sformatf({"mismatch: expected status %0d time %h kind %0d data %h",
                                " occ %0d, got status %0d time %h kind %0d data %h occ %0d"},
                               exp_res.status, exp_res.ev_time, exp_res.ev_kind,
                               exp_res.ev_data, exp_res.occupancy, got.status,
                               got.ev_time, got.ev_kind, got.ev_data, got.occupancy));
    end
  endtask

  // predict on every accepted request, check on every accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        pending_results.push_back(apply_to_shadow(toeq_pkg::op_t'(in_operation),
                                                  in_event_time, in_event_kind,
                                                  in_event_data));
      if (out_valid && out_ready)
        check_result();
    end
  end

  // result side back-pressure
  initial begin
    int stall;
    int run;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (steady_flow) begin
        stall = 0;
        run = 1;
      end else begin
        stall = $urandom_range(0, 99);
        stall = (stall < 50) ? 0 : (stall < 90) ? $urandom_range(1, 3)
                                                : $urandom_range(4, 40);
        run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(20, 60);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
    end
  end

  // ends the run if nothing moves on either side for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timestamp_ordered_event_queue test failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (steady_flow)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // mix of tie-heavy small values, extremes and full-range values
  function automatic logic [31:0] pick_time(bit tie_heavy);
    int r;
    r = $urandom_range(0, 99);
    if (tie_heavy || r < 35)
      return 32'($urandom_range(0, 15));
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h7FFF_FFFF;
        default: return 32'h8000_0000;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_request(toeq_pkg::op_t op, logic [31:0] t, logic k, logic [31:0] d);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_event_time <= t;
    in_event_kind <= k;
    in_event_data <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic push_event(logic [31:0] t, logic k, logic [31:0] d);
    send_request(toeq_pkg::OP_PUSH, t, k, d);
  endtask

  // pop carries random junk in the unused fields
  task automatic pop_event();
    send_request(toeq_pkg::OP_POP, $urandom, 1'($urandom), $urandom);
  endtask

  task automatic test_empty_pop();
    pop_event();
    pop_event();
  endtask

  task automatic test_field_extremes();
    push_event(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    push_event(32'h0000_0000, 1'b0, 32'h0000_0000);
    push_event(32'h8000_0000, 1'b1, 32'hA5A5_A5A5);
    push_event(32'h7FFF_FFFF, 1'b0, 32'h5A5A_5A5A);
    repeat (4) pop_event();
    pop_event();
  endtask

  // equal timestamps must come out in arrival order
  task automatic test_equal_times();
    push_event(32'd100, 1'b0, 32'd1);
    push_event(32'd100, 1'b1, 32'd2);
    push_event(32'd50, 1'b0, 32'd3);
    push_event(32'd100, 1'b0, 32'd4);
    push_event(32'd150, 1'b1, 32'd5);
    push_event(32'd100, 1'b1, 32'd6);
    repeat (6) pop_event();
  endtask

  task automatic test_fill_and_drain(bit tie_heavy);
    repeat (toeq_pkg::DEPTH + 3) push_event(pick_time(tie_heavy), 1'($urandom), $urandom);
    repeat (toeq_pkg::DEPTH + 3) pop_event();
  endtask

  // phases of push-heavy and pop-heavy traffic so occupancy sweeps the range
  task automatic test_random_traffic(int n_requests);
    int push_pct;
    push_pct = 50;
    for (int i = 0; i < n_requests; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 4))
          0: push_pct = 90;
          1: push_pct = 75;
          2: push_pct = 50;
          3: push_pct = 25;
          default: push_pct = 10;
        endcase
        steady_flow = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < push_pct)
        push_event(pick_time(1'b0), 1'($urandom), $urandom);
      else
        pop_event();
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = toeq_pkg::OP_PUSH;
    in_event_time = '0;
    in_event_kind = 1'b0;
    in_event_data = '0;
    steady_flow = 1'b0;
    fail_count = 0;
    shadow_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_pop();
    test_field_extremes();
    test_equal_times();
    test_fill_and_drain(1'b0);
    test_fill_and_drain(1'b1);
    test_random_traffic(1100);

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0)
      note_failure("results still outstanding at end of run");
    if (fail_count == 0)
      $display("timestamp_ordered_event_queue test passed");
    else
      $display("timestamp_ordered_event_queue test failed");
    $finish;
  end

endmodule
